FILE: rtl/core/dhts_pkg.sv
package dhts_pkg;

    // Table geometry defaults
    localparam int TABLE_SIZE_DEF = 1024;
    localparam int STAMP_BITS_DEF = 8;

    // Field widths
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int CFG_W    = 11;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    // Stream and register port widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // Hashing
    localparam logic [KEY_W-1:0] HASH_MUL = 32'd2654435769;
    localparam int STEP_SHIFT = 15;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 11'd512;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_WRITE  = 2'd1,
        OP_ACCESS = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_CREATED = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        FSM_SWEEP = 3'd0,
        FSM_IDLE  = 3'd1,
        FSM_PROBE = 3'd2,
        FSM_CMP   = 3'd3,
        FSM_DONE  = 3'd4
    } t_state;

endpackage

FILE: rtl/core/double_hash_table_with_stamps_core.sv
// Each item walks PROBE (one tag/data memory read) and CMP (compare) once per probe,
// probes between 1 and TABLE_SIZE, then waits in DONE until the output register is free.
// A new item is accepted only in IDLE, after DONE has loaded the previous result.
// A clear goes straight to DONE; a clear at the top stamp value first sweeps all TABLE_SIZE
// entries of the stamp memory. After reset, a sweep of the whole table zeroes all stamps
// before the first item is accepted; register writes are taken throughout.
module double_hash_table_with_stamps_core #(
    parameter int TABLE_SIZE = dhts_pkg::TABLE_SIZE_DEF,
    parameter int STAMP_BITS = dhts_pkg::STAMP_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dhts_pkg::APB_AW-1:0]    paddr,
    input  logic [dhts_pkg::APB_DW-1:0]    pwdata,
    output logic [dhts_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    // request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [dhts_pkg::S_TDATA_W-1:0] s_axis_tdata,  // key[31:0], data_in[63:32]
    input  logic [dhts_pkg::OP_W-1:0]      s_axis_tuser,  // opcode[1:0]
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [dhts_pkg::M_TDATA_W-1:0] m_axis_tdata,  // data_out[31:0], entry_count[42:32]
    output logic [dhts_pkg::STATUS_W-1:0]  m_axis_tuser   // status[2:0]
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int KW    = dhts_pkg::KEY_W;
    localparam int DW    = dhts_pkg::DATA_W;
    localparam int CW    = dhts_pkg::COUNT_W;
    localparam int TAG_W = STAMP_BITS + KW;

    // Memories: tag = {stamp, key}, data
    logic [TAG_W-1:0] r_tag_mem  [TABLE_SIZE];
    logic [DW-1:0]    r_data_mem [TABLE_SIZE];
    logic [TAG_W-1:0] r_tag_rd;
    logic [DW-1:0]    r_data_rd;

    dhts_pkg::t_state r_state, n_state;

    // Control registers
    logic [dhts_pkg::CFG_W-1:0] r_max_entries;
    logic [STAMP_BITS-1:0]      r_live_stamp;
    logic [CW-1:0]              r_live_count;
    logic [IDX_W-1:0]           r_sweep_idx;
    logic                       r_sweep_emit;
    logic                       r_out_valid;

    // Item payload
    dhts_pkg::t_opcode    r_op;
    logic [KW-1:0]        r_key;
    logic [DW-1:0]        r_din;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     r_step;
    logic [IDX_W-1:0]     r_probe_n;
    dhts_pkg::t_status    r_res_status;
    logic [DW-1:0]        r_res_data;
    logic [CW-1:0]        r_res_count;
    dhts_pkg::t_status    r_out_status;
    logic [DW-1:0]        r_out_data;
    logic [CW-1:0]        r_out_count;

    // Combinational controls
    logic               w_in_fire;
    logic               w_is_clear;
    logic               w_wrap;
    logic [KW-1:0]      w_hash;
    logic               w_cfg_wr;
    logic               w_free;
    logic               w_hit;
    logic               w_last;
    logic               w_probe_done;
    logic               w_room;
    logic               w_out_load;
    logic               w_sweep_end;
    logic               w_rd_en;
    logic               w_tag_we;
    logic [IDX_W-1:0]   w_tag_waddr;
    logic [TAG_W-1:0]   w_tag_wdata;
    logic               w_data_we;
    logic [DW-1:0]      w_data_wdata;
    dhts_pkg::t_status  w_res_status;
    logic [DW-1:0]      w_res_data;
    logic               w_create;

    // Register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? dhts_pkg::APB_DW'(r_max_entries) : '0;

    // Input decode and hash
    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_is_clear = (dhts_pkg::t_opcode'(s_axis_tuser) == dhts_pkg::OP_CLEAR);
    assign w_wrap     = (r_live_stamp == {STAMP_BITS{1'b1}});
    assign w_hash     = s_axis_tdata[KW-1:0] * dhts_pkg::HASH_MUL;

    // Probe compare on the registered memory read
    assign w_free       = (r_tag_rd[TAG_W-1 -: STAMP_BITS] != r_live_stamp);
    assign w_hit        = !w_free && (r_tag_rd[KW-1:0] == r_key);
    assign w_last       = (r_probe_n == {IDX_W{1'b1}});
    assign w_probe_done = w_hit || w_free || w_last;
    assign w_room       = ({1'b0, r_live_count} + (CW+1)'(1)) < {1'b0, r_max_entries};
    assign w_create     = !w_hit && w_free && (r_op != dhts_pkg::OP_LOOKUP) && w_room;
    assign w_out_load   = !r_out_valid || m_axis_tready;
    assign w_sweep_end  = (r_sweep_idx == {IDX_W{1'b1}});

    // Result selection for a finished probe
    always_comb begin
        w_res_status = dhts_pkg::ST_MISS;
        w_res_data   = '0;
        if (w_hit) begin
            w_res_status = dhts_pkg::ST_HIT;
            w_res_data   = (r_op == dhts_pkg::OP_WRITE) ? r_din : r_data_rd;
        end else if (r_op == dhts_pkg::OP_LOOKUP) begin
            w_res_status = dhts_pkg::ST_MISS;
        end else if (w_create) begin
            w_res_status = dhts_pkg::ST_CREATED;
            w_res_data   = (r_op == dhts_pkg::OP_WRITE) ? r_din : '0;
        end else begin
            w_res_status = dhts_pkg::ST_FULL;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dhts_pkg::FSM_SWEEP: begin
                if (w_sweep_end) begin
                    n_state = r_sweep_emit ? dhts_pkg::FSM_DONE : dhts_pkg::FSM_IDLE;
                end
            end
            dhts_pkg::FSM_IDLE: begin
                if (w_in_fire) begin
                    if (w_is_clear) begin
                        n_state = w_wrap ? dhts_pkg::FSM_SWEEP : dhts_pkg::FSM_DONE;
                    end else begin
                        n_state = dhts_pkg::FSM_PROBE;
                    end
                end
            end
            dhts_pkg::FSM_PROBE: begin
                n_state = dhts_pkg::FSM_CMP;
            end
            dhts_pkg::FSM_CMP: begin
                n_state = w_probe_done ? dhts_pkg::FSM_DONE : dhts_pkg::FSM_PROBE;
            end
            dhts_pkg::FSM_DONE: begin
                if (w_out_load) begin
                    n_state = dhts_pkg::FSM_IDLE;
                end
            end
            default: n_state = dhts_pkg::FSM_IDLE;
        endcase
    end

    // State outputs: handshake and memory ports
    always_comb begin
        s_axis_tready = 1'b0;
        w_rd_en       = 1'b0;
        w_tag_we      = 1'b0;
        w_tag_waddr   = r_idx;
        w_tag_wdata   = {r_live_stamp, r_key};
        w_data_we     = 1'b0;
        w_data_wdata  = w_res_data;
        unique case (r_state)
            dhts_pkg::FSM_SWEEP: begin
                w_tag_we    = 1'b1;
                w_tag_waddr = r_sweep_idx;
                w_tag_wdata = '0;
            end
            dhts_pkg::FSM_IDLE: begin
                s_axis_tready = 1'b1;
            end
            dhts_pkg::FSM_PROBE: begin
                w_rd_en = 1'b1;
            end
            dhts_pkg::FSM_CMP: begin
                w_tag_we  = w_create;
                w_data_we = w_create || (w_hit && (r_op == dhts_pkg::OP_WRITE));
            end
            dhts_pkg::FSM_DONE: begin
                s_axis_tready = 1'b0;
            end
            default: s_axis_tready = 1'b0;
        endcase
    end

    // Tag memory
    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            r_tag_mem[w_tag_waddr] <= w_tag_wdata;
        end
        if (w_rd_en) begin
            r_tag_rd <= r_tag_mem[r_idx];
        end
    end

    // Data memory
    always_ff @(posedge i_clk) begin
        if (w_data_we) begin
            r_data_mem[r_idx] <= w_data_wdata;
        end
        if (w_rd_en) begin
            r_data_rd <= r_data_mem[r_idx];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= dhts_pkg::FSM_SWEEP;
            r_max_entries <= dhts_pkg::MAX_ENTRIES_RST;
            r_live_stamp  <= STAMP_BITS'(1);
            r_live_count  <= '0;
            r_sweep_idx   <= '0;
            r_sweep_emit  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_max_entries <= pwdata[dhts_pkg::CFG_W-1:0];
            end
            // clear: advance the stamp, or restart it behind a sweep
            if (w_in_fire && w_is_clear) begin
                r_live_count <= '0;
                r_sweep_idx  <= '0;
                r_sweep_emit <= 1'b1;
                r_live_stamp <= w_wrap ? STAMP_BITS'(1) : r_live_stamp + STAMP_BITS'(1);
            end else if (r_state == dhts_pkg::FSM_CMP && w_create) begin
                r_live_count <= r_live_count + CW'(1);
            end
            if (r_state == dhts_pkg::FSM_SWEEP) begin
                r_sweep_idx <= r_sweep_idx + IDX_W'(1);
            end
            // output register
            if (r_state == dhts_pkg::FSM_DONE && w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload and results
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op         <= dhts_pkg::t_opcode'(s_axis_tuser);
            r_key        <= s_axis_tdata[KW-1:0];
            r_din        <= s_axis_tdata[KW +: DW];
            r_idx        <= w_hash[IDX_W-1:0];
            r_step       <= w_hash[dhts_pkg::STEP_SHIFT +: IDX_W] | IDX_W'(1);
            r_probe_n    <= '0;
            r_res_status <= dhts_pkg::ST_CLEARED;
            r_res_data   <= '0;
            r_res_count  <= '0;
        end
        if (r_state == dhts_pkg::FSM_CMP) begin
            if (w_probe_done) begin
                r_res_status <= w_res_status;
                r_res_data   <= w_res_data;
                r_res_count  <= w_create ? r_live_count + CW'(1) : r_live_count;
            end else begin
                r_idx     <= r_idx + r_step;
                r_probe_n <= r_probe_n + IDX_W'(1);
            end
        end
        if (r_state == dhts_pkg::FSM_DONE && w_out_load) begin
            r_out_status <= r_res_status;
            r_out_data   <= r_res_data;
            r_out_count  <= r_res_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {{(dhts_pkg::M_TDATA_W - DW - CW){1'b0}}, r_out_count, r_out_data};

endmodule

FILE: test/testbench.sv
module testbench;
    import dhts_pkg::*;

    localparam int SLOTS     = TABLE_SIZE_DEF;
    localparam int STAMP_TOP = (1 << STAMP_BITS_DEF) - 1;

    // register map
    localparam logic [APB_AW-1:0] ADDR_MAX_ENTRIES = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_UNUSED      = 3'd4;

    // outcome of a probe walk
    typedef enum int {
        WALK_FREE,
        WALK_HIT,
        WALK_NO_ROOM
    } t_walk;

    typedef struct {
        t_status     status;
        logic [31:0] data_out;
        logic [10:0] count;
    } t_map_reply;

    // Shadow copy of the table: predicts each reply and checks the replies that come out
    class hash_map_mirror;
        logic [31:0]               key_mem   [SLOTS];
        logic [31:0]               value_mem [SLOTS];
        logic [STAMP_BITS_DEF-1:0] stamp_mem [SLOTS];
        logic [STAMP_BITS_DEF-1:0] epoch;
        logic [10:0]               entries;
        logic [10:0]               threshold;
        int                        failures;
        t_map_reply                pending_replies [$];

        function new();
            foreach (stamp_mem[i]) stamp_mem[i] = '0;
            epoch     = 1;
            entries   = '0;
            threshold = MAX_ENTRIES_RST;
            failures  = 0;
        endfunction

        // double-hash walk; stops at the key, at a stale slot, or after every slot
        function t_walk walk(logic [31:0] key, output int slot);
            logic [31:0] h;
            int pos;
            int stride;
            h      = key * HASH_MUL;
            pos    = int'(h & (SLOTS - 1));
            stride = int'((h >> STEP_SHIFT) | 32'd1);
            slot   = 0;
            for (int n = 0; n < SLOTS; n++) begin
                if (stamp_mem[pos] != epoch) begin
                    slot = pos;
                    return WALK_FREE;
                end
                if (key_mem[pos] == key) begin
                    slot = pos;
                    return WALK_HIT;
                end
                pos = (pos + stride) & (SLOTS - 1);
            end
            return WALK_NO_ROOM;
        endfunction

        function void note_request(t_opcode op, logic [31:0] key, logic [31:0] din);
            t_map_reply r;
            t_walk      found;
            int         slot;
            r.data_out = '0;
            if (op == OP_CLEAR) begin
                // clear bumps the epoch; at the top value all stamps are swept
                if (epoch >= STAMP_TOP) begin
                    foreach (stamp_mem[i]) stamp_mem[i] = '0;
                    epoch = 1;
                end else begin
                    epoch++;
                end
                entries  = '0;
                r.status = ST_CLEARED;
            end else begin
                found = walk(key, slot);
                if (found == WALK_HIT) begin
                    r.status = ST_HIT;
                    if (op == OP_WRITE) value_mem[slot] = din;
                    r.data_out = value_mem[slot];
                end else if (op == OP_LOOKUP) begin
                    r.status = ST_MISS;
                end else if (found == WALK_NO_ROOM || entries + 1 >= threshold) begin
                    r.status = ST_FULL;
                end else begin
                    entries++;
                    stamp_mem[slot] = epoch;
                    key_mem[slot]   = key;
                    value_mem[slot] = (op == OP_WRITE) ? din : '0;
                    r.data_out      = value_mem[slot];
                    r.status        = ST_CREATED;
                end
            end
            r.count = entries;
            pending_replies.push_back(r);
        endfunction

        function void check_result(logic [2:0] status, logic [31:0] dout, logic [10:0] count);
            t_map_reply r;
            if (pending_replies.size() == 0) begin
                $error("reply with status %0d arrived with no request pending", status);
                failures++;
                return;
            end
            r = pending_replies.pop_front();
            if (status !== r.status) begin
                $error("status: expected %0d, got %0d", r.status, status);
                failures++;
            end
            if (dout !== r.data_out) begin
                $error("data_out: expected %0h, got %0h", r.data_out, dout);
                failures++;
            end
            if (count !== r.count) begin
                $error("entry_count: expected %0d, got %0d", r.count, count);
                failures++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // key[31:0], data_in[63:32]
    logic [OP_W-1:0]       s_axis_tuser;   // opcode[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // data_out[31:0], entry_count[42:32]
    logic [STATUS_W-1:0]   m_axis_tuser;   // status[2:0]

    hash_map_mirror mirror;
    bit             gaps_on;
    bit             hold_results;
    bit             hold_done;
    int             sent;

    double_hash_table_with_stamps_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    initial begin
        #(10 * 1_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // transaction monitor: requests are predicted before replies are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                mirror.note_request(t_opcode'(s_axis_tuser), s_axis_tdata[31:0],
                                    s_axis_tdata[63:32]);
            if (m_axis_tvalid && m_axis_tready)
                mirror.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[42:32]);
        end
    end

    // result side back-pressure: random stalls plus one long hold on request
    initial begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_results && !hold_done) begin
                m_axis_tready = 1'b0;
                repeat (500) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (gaps_on && $urandom_range(0, 99) < 12) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // all tasks start and end just after a falling edge
    task automatic send_op(t_opcode op, logic [31:0] key, logic [31:0] din);
        if (gaps_on && $urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {din, key};
        s_axis_tuser  = op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (mirror.pending_replies.size() != 0) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [APB_AW-1:0] addr, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_MAX_ENTRIES) mirror.threshold = value[10:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic reg_read_check(logic [10:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_MAX_ENTRIES;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {21'd0, value}) begin
            $error("max_entries: expected %0d, got %0d", value, prdata);
            mirror.failures++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // threshold changes only with the block idle
    task automatic set_threshold(logic [31:0] value);
        drain();
        reg_write(ADDR_MAX_ENTRIES, value);
        reg_read_check(value[10:0]);
    endtask

    // random traffic on a small key pool, many keys sharing a start slot
    task automatic run_episode(int n_ops);
        logic [31:0] pool [16];
        logic [31:0] base;
        logic [31:0] key;
        logic [31:0] din;
        int          pool_n;
        int          r;
        t_opcode     op;
        pool_n = $urandom_range(1, 16);
        base   = $urandom;
        for (int i = 0; i < pool_n; i++) begin
            case ($urandom_range(0, 6))
                0:       pool[i] = $urandom;
                5:       pool[i] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                6:       pool[i] = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
                default: pool[i] = base + 32'd1024 * $urandom_range(0, 15);
            endcase
        end
        if ($urandom_range(0, 1) == 0) send_op(OP_CLEAR, $urandom, $urandom);
        for (int i = 0; i < n_ops; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4)       op = OP_CLEAR;
            else if (r < 36) op = OP_LOOKUP;
            else if (r < 68) op = OP_WRITE;
            else             op = OP_ACCESS;
            key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
            din = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
            send_op(op, key, din);
        end
    endtask

    // fill every slot with distinct keys, then probe a table with no free slot
    task automatic fill_table();
        logic [31:0] base;
        logic [31:0] stride;
        base   = $urandom;
        stride = $urandom | 32'd1;
        set_threshold(32'd2047);
        send_op(OP_CLEAR, $urandom, $urandom);
        for (int i = 0; i < SLOTS; i++)
            send_op($urandom_range(0, 1) ? OP_WRITE : OP_ACCESS, base + i * stride, $urandom);
        send_op(OP_ACCESS, base + SLOTS * stride, $urandom);
        send_op(OP_WRITE, base + SLOTS * stride, $urandom);
        send_op(OP_LOOKUP, base + SLOTS * stride, $urandom);
        send_op(OP_LOOKUP, base + 5 * stride, $urandom);
        send_op(OP_WRITE, base, $urandom);
        send_op(OP_ACCESS, base + (SLOTS - 1) * stride, $urandom);
        send_op(OP_CLEAR, $urandom, $urandom);
    endtask

    initial begin
        mirror        = new();
        gaps_on       = 1'b1;
        hold_results  = 1'b0;
        sent          = 0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOOKUP;
        i_rst_n       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: basic hits, misses, creates and field extremes
        reg_read_check(MAX_ENTRIES_RST);
        send_op(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_op(OP_WRITE,  32'h7FFF_FFFF, 32'h8000_0000);
        send_op(OP_WRITE,  32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_LOOKUP, 32'h7FFF_FFFF, 32'h1234_5678);
        send_op(OP_ACCESS, 32'h8000_0000, 32'h7FFF_FFFF);
        send_op(OP_ACCESS, 32'h8000_0000, 32'h0000_0000);
        send_op(OP_ACCESS, 32'hFFFF_FFFF, 32'h5555_5555);
        // keys 0, 0x400, 0x800 share a start slot
        send_op(OP_WRITE,  32'h0000_0000, 32'hAAAA_AAAA);
        send_op(OP_WRITE,  32'h0000_0400, 32'h0000_0001);
        send_op(OP_LOOKUP, 32'h0000_0400, 32'h0000_0000);
        send_op(OP_LOOKUP, 32'h0000_0800, 32'h0000_0000);
        send_op(OP_CLEAR,  32'hDEAD_BEEF, 32'hFFFF_FFFF);
        send_op(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);

        // smallest usable threshold: one entry, then refused
        set_threshold(32'd2);
        send_op(OP_WRITE,  32'h0000_0001, 32'h0000_0011);
        send_op(OP_WRITE,  32'h0000_0002, 32'h0000_0022);
        send_op(OP_ACCESS, 32'h0000_0003, 32'h0000_0000);
        send_op(OP_WRITE,  32'h0000_0001, 32'h0000_0033);

        // threshold of zero and one refuse every new key
        set_threshold(32'd0);
        send_op(OP_CLEAR,  32'h0000_0000, 32'h0000_0000);
        send_op(OP_ACCESS, 32'h0000_0004, 32'h0000_0000);
        send_op(OP_WRITE,  32'h0000_0005, 32'h0000_0005);
        set_threshold(32'd1);
        send_op(OP_ACCESS, 32'h0000_0006, 32'h0000_0000);

        // a write to an unused register index changes nothing
        drain();
        reg_write(ADDR_UNUSED, 32'h0000_0005);
        reg_read_check(11'd1);
        send_op(OP_WRITE, 32'h0000_0007, 32'h0000_0007);

        // upper bus bits are dropped
        set_threshold(32'hFFFF_F803);

        // random episodes under varied thresholds
        for (int ep = 0; sent < 100; ep++) begin
            case ($urandom_range(0, 5))
                0:       set_threshold(32'd2);
                1:       set_threshold($urandom_range(3, 12));
                2:       set_threshold($urandom_range(13, 40));
                3:       set_threshold(32'd512);
                4:       set_threshold(32'd1024);
                default: set_threshold($urandom_range(2, 1024));
            endcase
            if (ep == 1) hold_results = 1'b1;
            run_episode($urandom_range(10, 40));
        end

        // enough clears to wrap the stamp and force a sweep
        set_threshold(32'd64);
        for (int i = 0; i < 260; i++) begin
            if (i % 32 == 0) send_op(OP_WRITE, $urandom, $urandom);
            send_op(OP_CLEAR, $urandom, $urandom);
        end
        run_episode(30);

        fill_table();

        // last stretch without idling on either side
        drain();
        gaps_on = 1'b0;
        repeat (20) @(negedge i_clk);
        set_threshold($urandom_range(16, 64));
        run_episode(40);

        drain();
        repeat (2100) @(negedge i_clk);
        if (mirror.failures == 0 && mirror.pending_replies.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: double_hash_table_with_stamps_core.f
rtl/core/dhts_pkg.sv
rtl/core/double_hash_table_with_stamps_core.sv
test/testbench.sv
